[design/fsg_pkg.sv]
package fsg_pkg;

    localparam int MEMBERSHIP_FRAC_BITS = 10;
    localparam int ONE     = 1 << MEMBERSHIP_FRAC_BITS;
    localparam int MW      = MEMBERSHIP_FRAC_BITS + 1;
    localparam int GAIN_W  = 12;
    localparam int QW      = 12;
    localparam int PROD_W  = GAIN_W + MW;
    localparam int NUM_W   = PROD_W + 2;
    localparam int DEN_W   = MW + 2;
    localparam int IN_W    = 16;
    localparam int MAG_W   = IN_W + 1;
    localparam int BP_W    = 6;
    localparam int OFF_W   = 4;
    localparam int SEG_W   = 2;
    localparam int IDX_W   = 3;
    localparam int LVL_W   = 4;
    localparam int CODE_W  = 3;
    localparam int N_GAIN  = 7;
    localparam int N_TERM  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int LAT     = 4 + QW;

    localparam logic [LVL_W-1:0] CENTER = LVL_W'(4);
    localparam logic [IDX_W-1:0] SAT_IDX = IDX_W'(4);
    localparam logic [MW-1:0]    MU_ONE = MW'(ONE);

    typedef logic [4:0][BP_W-1:0] t_bp;
    typedef logic [N_GAIN-1:0][GAIN_W-1:0] t_gains;

    localparam t_bp ERR_BP = '{6'd55, 6'd40, 6'd25, 6'd10, 6'd0};
    localparam t_bp DER_BP = '{6'd17, 6'd12, 6'd7, 6'd3, 6'd0};

    localparam t_gains GAIN_RST = '{12'd2816, 12'd2688, 12'd2560, 12'd2432,
                                   12'd2304, 12'd2176, 12'd2048};

    localparam int MU_D10 [16] = '{0, ONE/10, 2*ONE/10, 3*ONE/10, 4*ONE/10,
        5*ONE/10, 6*ONE/10, 7*ONE/10, 8*ONE/10, 9*ONE/10, 10*ONE/10,
        0, 0, 0, 0, 0};
    localparam int MU_D15 [16] = '{0, ONE/15, 2*ONE/15, 3*ONE/15, 4*ONE/15,
        5*ONE/15, 6*ONE/15, 7*ONE/15, 8*ONE/15, 9*ONE/15, 10*ONE/15,
        11*ONE/15, 12*ONE/15, 13*ONE/15, 14*ONE/15, 15*ONE/15};
    localparam int MU_D3 [16] = '{0, ONE/3, 2*ONE/3, 3*ONE/3,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int MU_D4 [16] = '{0, ONE/4, 2*ONE/4, 3*ONE/4, 4*ONE/4,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int MU_D5 [16] = '{0, ONE/5, 2*ONE/5, 3*ONE/5, 4*ONE/5, 5*ONE/5,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    localparam logic [CODE_W-1:0] RULE_P [9][9] = '{
        '{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2},
        '{3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2},
        '{3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3},
        '{3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
        '{3'd3, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd3},
        '{3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
        '{3'd3, 3'd3, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4},
        '{3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4},
        '{3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4}
    };

    localparam logic [CODE_W-1:0] RULE_D [9][9] = '{
        '{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd0},
        '{3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd3, 3'd2, 3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd4},
        '{3'd4, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0, 3'd2, 3'd3, 3'd4},
        '{3'd4, 3'd3, 3'd2, 3'd2, 3'd0, 3'd2, 3'd2, 3'd3, 3'd4},
        '{3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
        '{3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4},
        '{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4}
    };

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [SEG_W-1:0] seg;
        logic [OFF_W-1:0] off;
    } t_fz;

    typedef struct packed {
        logic                           valid;
        logic [N_TERM-1:0][MW-1:0]      mu;
        logic [N_TERM-1:0][CODE_W-1:0]  code;
    } t_front;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_divin;

    function automatic t_fz fuzz_seg(input logic [IN_W-1:0] v, input t_bp bp);
        t_fz              r;
        logic [MAG_W-1:0] m;
        r.neg = v[IN_W-1];
        m = r.neg ? (MAG_W'(1 << IN_W) - {1'b0, v}) : {1'b0, v};
        r.sat = 1'b1;
        r.seg = '0;
        r.off = '0;
        for (int s = 3; s >= 0; s--) begin
            if (MAG_W'(bp[s+1]) >= m) begin
                r.sat = 1'b0;
                r.seg = SEG_W'(s);
            end
        end
        if (!r.sat) begin
            r.off = OFF_W'(m[BP_W-1:0] - bp[r.seg]);
        end
        return r;
    endfunction

    function automatic logic [MW-1:0] mu_err(input logic [SEG_W-1:0] seg,
                                             input logic [OFF_W-1:0] off);
        logic [MW-1:0] r;
        unique case (seg)
            2'd0:    r = MW'(MU_D10[off]);
            default: r = MW'(MU_D15[off]);
        endcase
        return r;
    endfunction

    function automatic logic [MW-1:0] mu_der(input logic [SEG_W-1:0] seg,
                                             input logic [OFF_W-1:0] off);
        logic [MW-1:0] r;
        unique case (seg)
            2'd0:    r = MW'(MU_D3[off]);
            2'd1:    r = MW'(MU_D4[off]);
            default: r = MW'(MU_D5[off]);
        endcase
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] mirror(input logic neg,
                                                input logic [IDX_W-1:0] idx);
        return neg ? (CENTER - LVL_W'(idx)) : (CENTER + LVL_W'(idx));
    endfunction

    function automatic logic [CODE_W-1:0] rule(input logic cmd,
                                               input logic [LVL_W-1:0] y,
                                               input logic [LVL_W-1:0] x);
        return cmd ? RULE_D[y][x] : RULE_P[y][x];
    endfunction

    function automatic logic [MW-1:0] min3(input logic [MW-1:0] a,
                                           input logic [MW-1:0] b,
                                           input logic [MW-1:0] c);
        logic [MW-1:0] r;
        r = a;
        if (b < r) r = b;
        if (c < r) r = c;
        return r;
    endfunction

endpackage

[design/fsg_front.sv]
module fsg_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_cmd,
    input  logic [fsg_pkg::IN_W-1:0]       i_error,
    input  logic [fsg_pkg::IN_W-1:0]       i_derror,
    output fsg_pkg::t_front                o_front
);

    logic            r_s1_vld;
    logic            r_s1_cmd;
    fsg_pkg::t_fz    r_s1_e;
    fsg_pkg::t_fz    r_s1_d;
    fsg_pkg::t_front r_s2;
    fsg_pkg::t_front n_s2;

    logic [fsg_pkg::MW-1:0]    e_hi, e_lo, d_hi, d_lo;
    logic [fsg_pkg::IDX_W-1:0] e_a, e_b, d_a, d_b;
    logic [fsg_pkg::LVL_W-1:0] x1, x2, y1, y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= i_cmd;
        r_s1_e   <= fsg_pkg::fuzz_seg(i_error, fsg_pkg::ERR_BP);
        r_s1_d   <= fsg_pkg::fuzz_seg(i_derror, fsg_pkg::DER_BP);
    end

    always_comb begin
        e_hi = r_s1_e.sat ? fsg_pkg::MU_ONE : fsg_pkg::mu_err(r_s1_e.seg, r_s1_e.off);
        e_lo = r_s1_e.sat ? fsg_pkg::MU_ONE : fsg_pkg::MU_ONE - e_hi;
        d_hi = r_s1_d.sat ? fsg_pkg::MU_ONE : fsg_pkg::mu_der(r_s1_d.seg, r_s1_d.off);
        d_lo = r_s1_d.sat ? fsg_pkg::MU_ONE : fsg_pkg::MU_ONE - d_hi;

        e_a = r_s1_e.sat ? fsg_pkg::SAT_IDX : fsg_pkg::IDX_W'(r_s1_e.seg);
        e_b = r_s1_e.sat ? fsg_pkg::SAT_IDX : fsg_pkg::IDX_W'(r_s1_e.seg) + 1'b1;
        d_a = r_s1_d.sat ? fsg_pkg::SAT_IDX : fsg_pkg::IDX_W'(r_s1_d.seg);
        d_b = r_s1_d.sat ? fsg_pkg::SAT_IDX : fsg_pkg::IDX_W'(r_s1_d.seg) + 1'b1;

        x1 = fsg_pkg::mirror(r_s1_e.neg, e_a);
        x2 = fsg_pkg::mirror(r_s1_e.neg, e_b);
        y1 = fsg_pkg::mirror(r_s1_d.neg, d_a);
        y2 = fsg_pkg::mirror(r_s1_d.neg, d_b);

        n_s2.valid   = r_s1_vld;
        n_s2.mu[0]   = fsg_pkg::min3(e_lo, d_lo, d_hi);
        n_s2.mu[1]   = fsg_pkg::min3(e_hi, d_lo, d_hi);
        n_s2.mu[2]   = d_lo;
        n_s2.mu[3]   = d_hi;
        n_s2.code[0] = fsg_pkg::rule(r_s1_cmd, y1, x1);
        n_s2.code[1] = fsg_pkg::rule(r_s1_cmd, y2, x1);
        n_s2.code[2] = fsg_pkg::rule(r_s1_cmd, y1, x2);
        n_s2.code[3] = fsg_pkg::rule(r_s1_cmd, y2, x2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2.mu   <= n_s2.mu;
        r_s2.code <= n_s2.code;
    end

    assign o_front = r_s2;

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid |-> (r_s2.mu[0] <= r_s2.mu[2] && r_s2.mu[0] <= r_s2.mu[3]
                        && r_s2.mu[1] <= r_s2.mu[2] && r_s2.mu[1] <= r_s2.mu[3]))
        else $error("error membership not clipped");

    a_der_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid |-> ((fsg_pkg::DEN_W'(r_s2.mu[2]) + fsg_pkg::DEN_W'(r_s2.mu[3])
                         == fsg_pkg::DEN_W'(fsg_pkg::ONE))
                        || (r_s2.mu[2] == fsg_pkg::MU_ONE && r_s2.mu[3] == fsg_pkg::MU_ONE)))
        else $error("change memberships do not sum to one");

endmodule

[design/fsg_wsum.sv]
module fsg_wsum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsg_pkg::t_front i_front,
    input  fsg_pkg::t_gains i_gains,
    output fsg_pkg::t_divin o_div
);

    logic                        r_s3_vld;
    logic [fsg_pkg::PROD_W-1:0]  r_prod [fsg_pkg::N_TERM];
    logic [fsg_pkg::DEN_W-1:0]   r_s3_den;
    logic [fsg_pkg::GAIN_W-1:0]  g [fsg_pkg::N_TERM];
    logic [fsg_pkg::DEN_W-1:0]   n_den;
    fsg_pkg::t_divin             r_s4;

    always_comb begin
        for (int k = 0; k < fsg_pkg::N_TERM; k++) begin
            if (i_front.code[k] < fsg_pkg::CODE_W'(fsg_pkg::N_GAIN)) begin
                g[k] = i_gains[i_front.code[k]];
            end else begin
                g[k] = '0;
            end
        end
        n_den = fsg_pkg::DEN_W'(i_front.mu[0]) + fsg_pkg::DEN_W'(i_front.mu[1])
              + fsg_pkg::DEN_W'(i_front.mu[2]) + fsg_pkg::DEN_W'(i_front.mu[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld   <= 1'b0;
            r_s4.valid <= 1'b0;
        end else begin
            r_s3_vld   <= i_front.valid;
            r_s4.valid <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fsg_pkg::N_TERM; k++) begin
            r_prod[k] <= fsg_pkg::PROD_W'(g[k]) * fsg_pkg::PROD_W'(i_front.mu[k]);
        end
        r_s3_den <= n_den;
        r_s4.num <= fsg_pkg::NUM_W'(r_prod[0]) + fsg_pkg::NUM_W'(r_prod[1])
                  + fsg_pkg::NUM_W'(r_prod[2]) + fsg_pkg::NUM_W'(r_prod[3]);
        r_s4.den <= r_s3_den;
    end

    assign o_div = r_s4;

endmodule

[design/fsg_div.sv]
module fsg_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fsg_pkg::t_divin          i_div,
    output logic                     o_valid,
    output logic [fsg_pkg::QW-1:0]   o_quot
);

    logic                         r_vld [fsg_pkg::QW];
    logic [fsg_pkg::NUM_W-1:0]    r_rem [fsg_pkg::QW];
    logic [fsg_pkg::DEN_W-1:0]    r_den [fsg_pkg::QW];
    logic [fsg_pkg::QW-1:0]       r_q   [fsg_pkg::QW];

    for (genvar k = 0; k < fsg_pkg::QW; k++) begin : g_stage
        logic                       vld_in;
        logic [fsg_pkg::NUM_W-1:0]  rem_in;
        logic [fsg_pkg::DEN_W-1:0]  den_in;
        logic [fsg_pkg::QW-1:0]     q_in;
        logic [fsg_pkg::NUM_W-1:0]  sh;
        logic                       ge;

        if (k == 0) begin : g_first
            assign vld_in = i_div.valid;
            assign rem_in = i_div.num;
            assign den_in = i_div.den;
            assign q_in   = '0;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
        end

        assign sh = fsg_pkg::NUM_W'(den_in) << (fsg_pkg::QW - 1 - k);
        assign ge = (rem_in >= sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (rem_in - sh) : rem_in;
            r_den[k] <= den_in;
            r_q[k]   <= {q_in[fsg_pkg::QW-2:0], ge};
        end
    end

    assign o_valid = r_vld[fsg_pkg::QW-1];
    assign o_quot  = r_q[fsg_pkg::QW-1];

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div.valid |-> (i_div.den >= fsg_pkg::DEN_W'(fsg_pkg::ONE)))
        else $error("divisor below one");

    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem[fsg_pkg::QW-1] < fsg_pkg::NUM_W'(r_den[fsg_pkg::QW-1])))
        else $error("remainder not below divisor");

endmodule

[design/fuzzy_steering_gain_core.sv]
// Throughput: one item per cycle; busy stays low, start is taken every cycle.
// Items pass through four front stages and the 12-stage restoring divider (one quotient bit per stage).
// Reset (i_rst_n low, synchronous) clears all stage valid bits and loads the
// default gain levels; o_done is one cycle wide and the receiver cannot stall.
module fuzzy_steering_gain_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [fsg_pkg::IN_W-1:0]          i_error,
    input  logic [fsg_pkg::IN_W-1:0]          i_derror,
    output logic                              o_done,
    output logic [fsg_pkg::QW-1:0]            o_gain,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsg_pkg::GAIN_W-1:0]        i_cfg_data
);

    fsg_pkg::t_gains r_gain;
    fsg_pkg::t_front front;
    fsg_pkg::t_divin div_in;
    logic            accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= fsg_pkg::GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int k = 0; k < fsg_pkg::N_GAIN; k++) begin
                if (i_cfg_index == fsg_pkg::CFG_IDX_W'(k)) begin
                    r_gain[k] <= i_cfg_data;
                end
            end
        end
    end

    fsg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_cmd    (i_cmd),
        .i_error  (i_error),
        .i_derror (i_derror),
        .o_front  (front)
    );

    fsg_wsum u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .i_gains (r_gain),
        .o_div   (div_in)
    );

    fsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (div_in),
        .o_valid (o_done),
        .o_quot  (o_gain)
    );

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, fsg_pkg::LAT))
        else $error("result beat without matching accepted item");

endmodule

[tb/sv/tb_fuzzy_steering_gain_core.sv]
module tb_fuzzy_steering_gain_core;

    localparam int FRAC        = fsg_pkg::MEMBERSHIP_FRAC_BITS;
    localparam int UNIT        = 1 << FRAC;
    localparam int N_GAIN_REGS = 7;
    localparam logic [fsg_pkg::CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
    localparam int N_PHASES    = 7;
    localparam int RAND_PER_PHASE = 230;
    localparam int CYCLE_LIMIT = 200000;

    localparam int ERR_KNOT [5] = '{0, 10, 25, 40, 55};
    localparam int DER_KNOT [5] = '{0, 3, 7, 12, 17};

    localparam int P_RULES [9][9] = '{
        '{4, 4, 3, 3, 2, 1, 1, 1, 2},
        '{4, 3, 3, 3, 2, 1, 1, 2, 2},
        '{4, 3, 3, 2, 2, 1, 1, 2, 3},
        '{3, 3, 2, 1, 1, 1, 2, 3, 3},
        '{3, 3, 2, 1, 0, 1, 2, 3, 3},
        '{3, 3, 2, 1, 1, 1, 2, 3, 3},
        '{3, 3, 1, 1, 2, 2, 2, 3, 4},
        '{2, 2, 1, 1, 2, 3, 3, 3, 4},
        '{2, 2, 1, 1, 2, 3, 3, 4, 4}
    };

    localparam int D_RULES [9][9] = '{
        '{4, 4, 3, 3, 2, 2, 2, 1, 0},
        '{4, 3, 3, 2, 1, 2, 1, 1, 0},
        '{4, 3, 2, 2, 1, 2, 1, 2, 3},
        '{4, 3, 2, 2, 0, 2, 2, 3, 4},
        '{4, 3, 2, 0, 0, 0, 2, 3, 4},
        '{4, 3, 2, 2, 0, 2, 2, 3, 4},
        '{3, 2, 1, 2, 1, 2, 2, 3, 4},
        '{0, 1, 1, 2, 1, 2, 3, 3, 4},
        '{0, 1, 2, 2, 2, 3, 3, 4, 4}
    };

    typedef struct packed {
        logic                        cmd;
        logic [fsg_pkg::IN_W-1:0]    err;
        logic [fsg_pkg::IN_W-1:0]    derr;
    } steer_sample_t;

    typedef struct {
        int lvl_lo;
        int lvl_hi;
        int mu_lo;
        int mu_hi;
    } grade_t;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              i_cmd = 1'b0;
    logic [fsg_pkg::IN_W-1:0]          i_error = '0;
    logic [fsg_pkg::IN_W-1:0]          i_derror = '0;
    logic                              o_done;
    logic [fsg_pkg::QW-1:0]            o_gain;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [fsg_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [fsg_pkg::GAIN_W-1:0]        i_cfg_data = '0;

    steer_sample_t              sample_q[$];
    logic [fsg_pkg::QW-1:0]     gain_due_q[$];
    logic [fsg_pkg::GAIN_W-1:0] gain_level_mirror [N_GAIN_REGS];
    int                         mismatch_cnt = 0;
    int                         cycle_cnt = 0;
    int                         burst_left = 1;
    int                         gap_left = 0;

    fuzzy_steering_gain_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_error     (i_error),
        .i_derror    (i_derror),
        .o_done      (o_done),
        .o_gain      (o_gain),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic grade_t grade(input logic [fsg_pkg::IN_W-1:0] v, input int knot [5]);
        grade_t g;
        int     mag;
        int     a;
        int     b;
        int     h;
        mag = v[fsg_pkg::IN_W-1] ? (65536 - int'({16'b0, v})) : int'({16'b0, v});
        g.mu_lo = UNIT;
        g.mu_hi = UNIT;
        a = 4;
        b = 4;
        for (int s = 0; s < 4; s++) begin
            if (mag <= knot[s+1]) begin
                h = ((mag - knot[s]) * UNIT) / (knot[s+1] - knot[s]);
                g.mu_hi = h;
                g.mu_lo = UNIT - h;
                a = s;
                b = s + 1;
                break;
            end
        end
        g.lvl_lo = v[fsg_pkg::IN_W-1] ? 4 - a : 4 + a;
        g.lvl_hi = v[fsg_pkg::IN_W-1] ? 4 - b : 4 + b;
        return g;
    endfunction

    function automatic int level_of(input logic cmd, input int y, input int x);
        return int'(gain_level_mirror[cmd ? D_RULES[y][x] : P_RULES[y][x]]);
    endfunction

    function automatic logic [fsg_pkg::QW-1:0] predict_gain(input steer_sample_t smp);
        grade_t  ex;
        grade_t  dy;
        int      floor_mu;
        longint  num;
        longint  den;
        ex = grade(smp.err, ERR_KNOT);
        dy = grade(smp.derr, DER_KNOT);
        floor_mu = (dy.mu_lo < dy.mu_hi) ? dy.mu_lo : dy.mu_hi;
        if (ex.mu_lo > floor_mu) ex.mu_lo = floor_mu;
        if (ex.mu_hi > floor_mu) ex.mu_hi = floor_mu;
        num = longint'(level_of(smp.cmd, dy.lvl_lo, ex.lvl_lo)) * ex.mu_lo
            + longint'(level_of(smp.cmd, dy.lvl_hi, ex.lvl_lo)) * ex.mu_hi
            + longint'(level_of(smp.cmd, dy.lvl_lo, ex.lvl_hi)) * dy.mu_lo
            + longint'(level_of(smp.cmd, dy.lvl_hi, ex.lvl_hi)) * dy.mu_hi;
        den = longint'(ex.mu_lo) + ex.mu_hi + dy.mu_lo + dy.mu_hi;
        return fsg_pkg::QW'(num / den);
    endfunction

    function automatic steer_sample_t random_sample();
        steer_sample_t smp;
        int            kind;
        int            knots [28];
        knots = '{0, 1, 9, 10, 11, 24, 25, 26, 39, 40, 41, 54, 55, 56,
                  2, 3, 4, 6, 7, 8, 12, 13, 16, 17, 18, 100, 32767, 32768};
        kind = $urandom_range(0, 9);
        smp.cmd = 1'($urandom_range(0, 1));
        if (kind <= 5) begin
            smp.err  = 16'(int'($urandom_range(0, 140)) - 70);
            smp.derr = 16'(int'($urandom_range(0, 50)) - 25);
        end else if (kind <= 7) begin
            smp.err  = 16'(int'($urandom_range(0, 140)) - 70);
            smp.derr = 16'($urandom());
        end else if (kind == 8) begin
            smp.err  = 16'($urandom());
            smp.derr = 16'($urandom());
        end else begin
            smp.err  = 16'(knots[$urandom_range(0, 27)]);
            smp.derr = 16'(knots[$urandom_range(0, 27)]);
            if ($urandom_range(0, 1)) smp.err = -smp.err;
            if ($urandom_range(0, 1)) smp.derr = -smp.derr;
        end
        return smp;
    endfunction

    task automatic write_gain_level(input logic [fsg_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [fsg_pkg::GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx < N_GAIN_REGS) gain_level_mirror[idx] = val;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || start || gain_due_q.size() != 0);
    endtask

    always @(posedge i_clk) begin : driver
        steer_sample_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                gain_due_q.push_back(predict_gain('{i_cmd, i_error, i_derror}));
            end
            if (start && busy) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (sample_q.size() != 0) begin
                nxt = sample_q.pop_front();
                start    <= 1'b1;
                i_cmd    <= nxt.cmd;
                i_error  <= nxt.err;
                i_derror <= nxt.derr;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [fsg_pkg::QW-1:0] due;
        if (i_rst_n && o_done === 1'b1) begin
            if (gain_due_q.size() == 0) begin
                $display("%0t: unexpected gain beat, expected none, actual %0d", $time, o_gain);
                mismatch_cnt++;
            end else begin
                due = gain_due_q.pop_front();
                if (o_gain !== due) begin
                    $display("%0t: gain mismatch, expected %0d, actual %0d", $time, due, o_gain);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int                         dir_err [13];
        int                         dir_der [13];
        logic [fsg_pkg::GAIN_W-1:0] val;
        dir_err = '{0, 10, 25, 40, 55, 56, -1, -10, -55, -56, 32767, -32767, -32768};
        dir_der = '{0, 3, 7, 12, 17, 18, -3, -7, -17, -18, 32767, -32767, -32768};
        for (int k = 0; k < N_GAIN_REGS; k++) gain_level_mirror[k] = 12'(2048 + 128 * k);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 13; k++) begin
            sample_q.push_back('{1'(k), 16'(dir_err[k]), 16'(dir_der[k])});
            sample_q.push_back('{1'(~k), 16'(dir_err[k]), 16'(dir_der[12 - k])});
        end
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                for (int k = 0; k < N_GAIN_REGS; k++) begin
                    case (p)
                        1:       val = 12'hFFF;
                        2:       val = 12'h000;
                        3:       val = (k % 2) ? 12'hFFF : 12'h000;
                        4:       val = 12'(4095 - 600 * k);
                        default: val = 12'($urandom());
                    endcase
                    write_gain_level(3'(k), val);
                end
                write_gain_level(UNUSED_REG_IDX, 12'($urandom()));
                i_cfg_valid <= 1'b0;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) sample_q.push_back(random_sample());
            wait_drained();
        end
        repeat (fsg_pkg::LAT + 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && gain_due_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
